/* src/gklf_pkg.sv */
// ---------------------------------------------------------------------------
// gklf_pkg
// shared types, codes and helpers of the glyph kerning line fitter
// ---------------------------------------------------------------------------
package gklf_pkg;

  localparam int MAX_ROWS_DEF       = 32;
  localparam int MAX_TEXT_BYTES_DEF = 4096;

  localparam int ROW_W     = 32;
  localparam int FW_W      = 6;
  localparam int DIM_W     = 12;
  localparam int LW_W      = 14;
  localparam int CB_W      = 13;
  localparam int BL_W      = 3;
  localparam int CLS_W     = 2;
  localparam int CFG_IDX_W = 2;

  localparam int WIDTH_MAX = 8191;
  localparam int WIDTH_MIN = -8192;

  // character classes
  localparam logic [CLS_W-1:0] CLS_ORD   = 2'd0;
  localparam logic [CLS_W-1:0] CLS_SPACE = 2'd1;
  localparam logic [CLS_W-1:0] CLS_PUNCT = 2'd2;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FONT_WIDTH,
    CFG_FONT_HEIGHT,
    CFG_BOX_WIDTH,
    CFG_LINE_INDENT
  } cfg_idx_t;

  typedef enum logic [1:0] {
    KM_NONE,
    KM_PREV,
    KM_SOLID
  } kmode_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CHK,
    ST_SCAN,
    ST_FIT
  } state_t;

  typedef struct packed {
    logic clr;
    logic rd_en;
    logic solid;
  } scan_ctl_t;

  typedef struct packed {
    logic [FW_W-1:0] prev_trim;
    logic [FW_W-1:0] font_width;
    kmode_t          mode;
    logic            first_glyph;
    logic            is_space;
  } fit_in_t;

  typedef struct packed {
    logic [FW_W-1:0] kern;
    logic [FW_W-1:0] trim;
    kmode_t          mode;
  } fit_out_t;

  function automatic logic signed [LW_W-1:0] sat_w(input logic signed [15:0] v);
    logic signed [LW_W-1:0] r;
    if (v > 16'(WIDTH_MAX)) begin
      r = LW_W'(WIDTH_MAX);
    end else if (v < 16'(WIDTH_MIN)) begin
      r = LW_W'(WIDTH_MIN);
    end else begin
      r = v[LW_W-1:0];
    end
    return r;
  endfunction

endpackage

/* src/gklf_ifs.sv */
// ---------------------------------------------------------------------------
// gklf channel interfaces
// row input, glyph result and register write channels
// ---------------------------------------------------------------------------
interface gklf_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] row_bits;
  logic        last_row;
  logic        start_of_text;
  logic [1:0]  char_class;
  logic [2:0]  byte_len;
  modport source(output valid, row_bits, last_row, start_of_text, char_class, byte_len,
                 input ready);
  modport sink(input valid, row_bits, last_row, start_of_text, char_class, byte_len,
               output ready);
endinterface

interface gklf_out_if;
  logic               valid;
  logic               ready;
  logic [5:0]         kern_px;
  logic [5:0]         glyph_width;
  logic signed [13:0] line_width;
  logic               line_full;
  logic [12:0]        committed_bytes;
  logic               wrapped;
  modport source(output valid, kern_px, glyph_width, line_width, line_full,
                 committed_bytes, wrapped, input ready);
  modport sink(input valid, kern_px, glyph_width, line_width, line_full,
               committed_bytes, wrapped, output ready);
endinterface

interface gklf_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

/* src/glyph_kerning_line_fitter.sv */
// ---------------------------------------------------------------------------
// glyph_kerning_line_fitter
// kerns and trims glyphs row by row and fits them into a text line
// ---------------------------------------------------------------------------
// a row that is not the last of its glyph is stored on accept and the block stays idle
// the last row of a glyph is accepted, then passes a check state, a scan state and a fit
//   state; the scan reads one memory entry a cycle, then waits for the last read data
// a glyph that is dropped or reported full before fitting skips the scan and fit states
// a result waits in an output register; the fit or report stalls while it is occupied
// rst_n (synchronous) restores register defaults and an empty line
module glyph_kerning_line_fitter #(
  parameter int MAX_ROWS       = gklf_pkg::MAX_ROWS_DEF,
  parameter int MAX_TEXT_BYTES = gklf_pkg::MAX_TEXT_BYTES_DEF
) (
  input  logic  clk,
  input  logic  rst_n,
  gklf_in_if.sink   in_if,
  gklf_out_if.source out_if,
  gklf_cfg_if.sink  cfg_if
);

  localparam int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int CW = $clog2(MAX_ROWS + 1);
  localparam int BW = $clog2(MAX_TEXT_BYTES + 1);

  // configuration registers
  logic [5:0]  font_width_r, font_height_r;
  logic [11:0] box_width_r, line_indent_r;

  // control
  gklf_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]    rc_r, rc_nxt, cnt_r, cnt_nxt, sa_r, sa_nxt;
  logic [1:0]       cls_r, cls_nxt;
  logic [2:0]       blen_r, blen_nxt;

  // text layout state
  logic [5:0]              prev_trim_r, prev_trim_nxt;
  gklf_pkg::kmode_t        kmode_r, kmode_nxt;
  logic                    first_r, first_nxt, full_r, full_nxt;
  logic signed [13:0]      rw_r, rw_nxt, bw_r, bw_nxt;
  logic [BW-1:0]           bu_r, bu_nxt, bb_r, bb_nxt;

  // result register
  logic                    ov_r, ov_nxt, load;
  logic [5:0]              o_kern_r, o_kern_nxt, o_gw_r, o_gw_nxt;
  logic signed [13:0]      o_lw_r, o_lw_nxt;
  logic                    o_full_r, o_full_nxt, o_wrap_r, o_wrap_nxt;
  logic [12:0]             o_cb_r, o_cb_nxt;

  // datapath
  logic                    acc_in, out_free, wr_en;
  logic [CW-1:0]           h_rows, rc_eff, rc_inc;
  gklf_pkg::scan_ctl_t     sctl;
  logic [31:1]             coll_acc;
  logic [31:0]             union_acc;
  gklf_pkg::fit_in_t       fin;
  gklf_pkg::fit_out_t      fout;
  gklf_pkg::kmode_t        mode_eff;
  logic signed [15:0]      rw16, chk_sum, fit_sum, box16;
  logic signed [13:0]      rw_fit, bw_sp, bw_fit;
  logic [BW:0]             bu_sum, bb_sp;
  logic [BW-1:0]           bu_fit, bb_fit;
  logic                    is_space, is_punct, full_now, full_fit;

  assign acc_in   = in_if.valid && in_if.ready;
  assign out_free = !ov_r || out_if.ready;
  assign in_if.ready  = (state_r == gklf_pkg::ST_IDLE);
  assign cfg_if.ready = 1'b1;

  // usable rows: font height capped at the memory depth
  assign h_rows = (8'(font_height_r) > 8'(MAX_ROWS)) ? CW'(MAX_ROWS) : CW'(font_height_r);
  // start of text restarts the row count
  assign rc_eff = in_if.start_of_text ? '0 : rc_r;
  assign rc_inc = (rc_eff < CW'(MAX_ROWS)) ? rc_eff + CW'(1) : rc_eff;
  assign wr_en  = acc_in && (rc_eff < h_rows);

  assign is_space = (cls_r == gklf_pkg::CLS_SPACE);
  assign is_punct = (cls_r == gklf_pkg::CLS_PUNCT);
  // a space after a glyph kerns against a solid block
  assign mode_eff = (is_space && kmode_r != gklf_pkg::KM_NONE) ? gklf_pkg::KM_SOLID : kmode_r;

  assign sctl.clr   = (state_r == gklf_pkg::ST_CHK);
  assign sctl.rd_en = (state_r == gklf_pkg::ST_SCAN) && (sa_r < CW'(MAX_ROWS));
  assign sctl.solid = (mode_eff == gklf_pkg::KM_SOLID);

  gklf_row_store #(.MAX_ROWS(MAX_ROWS), .AW(AW), .CW(CW)) u_rows (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_en     (wr_en),
    .wr_addr   (rc_eff[AW-1:0]),
    .wr_data   (in_if.row_bits),
    .ctl       (sctl),
    .rd_addr   (sa_r[AW-1:0]),
    .row_cnt   (cnt_r),
    .h_rows    (h_rows),
    .coll_acc  (coll_acc),
    .union_acc (union_acc)
  );

  assign fin.prev_trim   = prev_trim_r;
  assign fin.font_width  = font_width_r;
  assign fin.mode        = mode_eff;
  assign fin.first_glyph = first_r;
  assign fin.is_space    = is_space;

  gklf_kern_fit u_fit (
    .fin       (fin),
    .coll_acc  (coll_acc),
    .union_acc (union_acc),
    .fout      (fout)
  );

  // layout arithmetic for the fitted glyph
  always_comb begin
    box16    = $signed({4'b0, box_width_r});
    rw16     = 16'(rw_r);
    chk_sum  = rw16 + $signed({4'b0, line_indent_r});
    full_now = (chk_sum >= box16);

    bw_sp  = gklf_pkg::sat_w(rw16 - $signed({10'b0, fout.kern}));
    rw_fit = gklf_pkg::sat_w(rw16 - $signed({10'b0, fout.kern})
                             + $signed({10'b0, fout.trim}) + 16'sd1);
    bb_sp  = (BW+1)'(bu_r) + (BW+1)'(blen_r);
    bu_sum = bb_sp;
    bu_fit = (bu_sum > (BW+1)'(MAX_TEXT_BYTES)) ? BW'(MAX_TEXT_BYTES) : bu_sum[BW-1:0];

    bb_fit = bb_r;
    bw_fit = bw_r;
    if (is_space) begin
      bb_fit = (bb_sp > (BW+1)'(MAX_TEXT_BYTES)) ? BW'(MAX_TEXT_BYTES) : bb_sp[BW-1:0];
      bw_fit = bw_sp;
    end
    if (is_punct) begin
      bb_fit = bu_fit;
      bw_fit = rw_fit;
    end
    fit_sum  = 16'(rw_fit) + $signed({4'b0, line_indent_r});
    full_fit = (fit_sum >= box16);
  end

  // next state and register updates
  always_comb begin
    state_nxt     = state_r;
    rc_nxt        = rc_r;
    cnt_nxt       = cnt_r;
    sa_nxt        = sa_r;
    cls_nxt       = cls_r;
    blen_nxt      = blen_r;
    prev_trim_nxt = prev_trim_r;
    kmode_nxt     = kmode_r;
    first_nxt     = first_r;
    full_nxt      = full_r;
    rw_nxt        = rw_r;
    bw_nxt        = bw_r;
    bu_nxt        = bu_r;
    bb_nxt        = bb_r;
    load          = 1'b0;
    o_kern_nxt    = o_kern_r;
    o_gw_nxt      = o_gw_r;
    o_lw_nxt      = o_lw_r;
    o_full_nxt    = o_full_r;
    o_cb_nxt      = o_cb_r;
    o_wrap_nxt    = o_wrap_r;

    unique case (state_r)
      gklf_pkg::ST_IDLE: begin
        if (acc_in) begin
          if (in_if.start_of_text) begin
            // new string: empty line, no previous glyph
            prev_trim_nxt = font_width_r;
            kmode_nxt     = gklf_pkg::KM_NONE;
            first_nxt     = 1'b1;
            full_nxt      = 1'b0;
            rw_nxt        = '0;
            bw_nxt        = '0;
            bu_nxt        = '0;
            bb_nxt        = '0;
          end
          if (in_if.last_row) begin
            cnt_nxt   = rc_inc;
            rc_nxt    = '0;
            cls_nxt   = in_if.char_class;
            blen_nxt  = in_if.byte_len;
            state_nxt = gklf_pkg::ST_CHK;
          end else begin
            rc_nxt = rc_inc;
          end
        end
      end
      gklf_pkg::ST_CHK: begin
        if (full_r || bu_r >= BW'(MAX_TEXT_BYTES)) begin
          // line closed or text store exhausted: glyph dropped
          state_nxt = gklf_pkg::ST_IDLE;
        end else if (full_now) begin
          // already full before this glyph: report without consuming it
          if (out_free) begin
            load       = 1'b1;
            full_nxt   = 1'b1;
            o_kern_nxt = '0;
            o_gw_nxt   = '0;
            o_full_nxt = 1'b1;
            o_wrap_nxt = (bb_r != '0);
            o_lw_nxt   = (bb_r != '0) ? bw_r : rw_r;
            o_cb_nxt   = (bb_r != '0) ? 13'(bb_r) : 13'(bu_r);
            state_nxt  = gklf_pkg::ST_IDLE;
          end
        end else begin
          sa_nxt    = '0;
          state_nxt = gklf_pkg::ST_SCAN;
        end
      end
      gklf_pkg::ST_SCAN: begin
        // one memory entry a cycle, last data lands the cycle after its read
        if (sa_r < CW'(MAX_ROWS)) begin
          sa_nxt = sa_r + CW'(1);
        end else begin
          state_nxt = gklf_pkg::ST_FIT;
        end
      end
      gklf_pkg::ST_FIT: begin
        if (out_free) begin
          load          = 1'b1;
          prev_trim_nxt = fout.trim;
          kmode_nxt     = fout.mode;
          first_nxt     = 1'b0;
          rw_nxt        = rw_fit;
          bw_nxt        = bw_fit;
          bu_nxt        = bu_fit;
          bb_nxt        = bb_fit;
          o_kern_nxt    = fout.kern;
          o_gw_nxt      = fout.trim;
          if (full_fit) begin
            full_nxt   = 1'b1;
            o_full_nxt = 1'b1;
            o_wrap_nxt = (bb_fit != '0);
            o_lw_nxt   = (bb_fit != '0) ? bw_fit : rw_fit;
            o_cb_nxt   = (bb_fit != '0) ? 13'(bb_fit) : 13'(bu_fit);
          end else begin
            o_full_nxt = 1'b0;
            o_wrap_nxt = 1'b0;
            o_lw_nxt   = rw_fit;
            o_cb_nxt   = 13'(bu_fit);
          end
          state_nxt = gklf_pkg::ST_IDLE;
        end
      end
      default: state_nxt = gklf_pkg::ST_IDLE;
    endcase

    ov_nxt = load ? 1'b1 : ((ov_r && out_if.ready) ? 1'b0 : ov_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= gklf_pkg::ST_IDLE;
      rc_r          <= '0;
      cnt_r         <= '0;
      sa_r          <= '0;
      cls_r         <= '0;
      blen_r        <= '0;
      prev_trim_r   <= 6'd8;
      kmode_r       <= gklf_pkg::KM_NONE;
      first_r       <= 1'b1;
      full_r        <= 1'b0;
      rw_r          <= '0;
      bu_r          <= '0;
      bb_r          <= '0;
      bw_r          <= '0;
      ov_r          <= 1'b0;
      font_width_r  <= 6'd8;
      font_height_r <= 6'd16;
      box_width_r   <= 12'd320;
      line_indent_r <= '0;
    end else begin
      state_r     <= state_nxt;
      rc_r        <= rc_nxt;
      cnt_r       <= cnt_nxt;
      sa_r        <= sa_nxt;
      cls_r       <= cls_nxt;
      blen_r      <= blen_nxt;
      prev_trim_r <= prev_trim_nxt;
      kmode_r     <= kmode_nxt;
      first_r     <= first_nxt;
      full_r      <= full_nxt;
      rw_r        <= rw_nxt;
      bu_r        <= bu_nxt;
      bb_r        <= bb_nxt;
      bw_r        <= bw_nxt;
      ov_r        <= ov_nxt;
      if (cfg_if.valid) begin
        unique case (gklf_pkg::cfg_idx_t'(cfg_if.index))
          gklf_pkg::CFG_FONT_WIDTH:  font_width_r  <= cfg_if.data[5:0];
          gklf_pkg::CFG_FONT_HEIGHT: font_height_r <= cfg_if.data[5:0];
          gklf_pkg::CFG_BOX_WIDTH:   box_width_r   <= cfg_if.data;
          gklf_pkg::CFG_LINE_INDENT: line_indent_r <= cfg_if.data;
          default: ;
        endcase
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    o_kern_r <= o_kern_nxt;
    o_gw_r   <= o_gw_nxt;
    o_lw_r   <= o_lw_nxt;
    o_full_r <= o_full_nxt;
    o_cb_r   <= o_cb_nxt;
    o_wrap_r <= o_wrap_nxt;
  end

  assign out_if.valid           = ov_r;
  assign out_if.kern_px         = o_kern_r;
  assign out_if.glyph_width     = o_gw_r;
  assign out_if.line_width      = o_lw_r;
  assign out_if.line_full       = o_full_r;
  assign out_if.committed_bytes = o_cb_r;
  assign out_if.wrapped         = o_wrap_r;

endmodule

/* src/gklf_row_store.sv */
// ---------------------------------------------------------------------------
// gklf_row_store
// current and previous glyph row memories with the collision scan
// ---------------------------------------------------------------------------
module gklf_row_store #(
  parameter int MAX_ROWS = gklf_pkg::MAX_ROWS_DEF,
  parameter int AW = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1,
  parameter int CW = $clog2(MAX_ROWS + 1)
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  logic [AW-1:0]        wr_addr,
  input  logic [31:0]          wr_data,
  input  gklf_pkg::scan_ctl_t  ctl,
  input  logic [AW-1:0]        rd_addr,
  input  logic [CW-1:0]        row_cnt,
  input  logic [CW-1:0]        h_rows,
  output logic [31:1]          coll_acc,
  output logic [31:0]          union_acc
);

  logic [31:0]   cur_mem  [MAX_ROWS];
  logic [31:0]   prev_mem [MAX_ROWS];
  logic [31:0]   cur_q, prev_q, cur_m, probe;
  logic          pv_r;
  logic [AW-1:0] pidx_r;
  logic [31:1]   coll_nxt;
  logic          in_h;

  // row write on accept, scan read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      cur_mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      cur_q  <= cur_mem[rd_addr];
      prev_q <= prev_mem[rd_addr];
    end
    if (pv_r) begin
      prev_mem[pidx_r] <= cur_m;
    end
  end

  always_comb begin
    in_h  = CW'(pidx_r) < h_rows;
    cur_m = (CW'(pidx_r) < row_cnt && in_h) ? cur_q : 32'h0;
    probe = ctl.solid ? 32'hffff_ffff : 32'h0;
    for (int s = 1; s < 32; s++) begin
      coll_nxt[s] = |(prev_q & ((cur_m | probe) >> s));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pv_r <= 1'b0;
    end else begin
      pv_r <= ctl.rd_en;
    end
    pidx_r <= rd_addr;
    if (ctl.clr) begin
      coll_acc  <= '0;
      union_acc <= '0;
    end else if (pv_r && in_h) begin
      coll_acc  <= coll_acc | coll_nxt;
      union_acc <= union_acc | cur_m;
    end
  end

endmodule

/* src/gklf_kern_fit.sv */
// ---------------------------------------------------------------------------
// gklf_kern_fit
// kern and trim search over the accumulated scan vectors
// ---------------------------------------------------------------------------
module gklf_kern_fit (
  input  gklf_pkg::fit_in_t  fin,
  input  logic [31:1]        coll_acc,
  input  logic [31:0]        union_acc,
  output gklf_pkg::fit_out_t fout
);

  logic [5:0] sp, fw, kt, ktr, tt, ttr, kern;
  logic       kf, tf;

  always_comb begin
    sp = fin.prev_trim;
    fw = fin.font_width;
    kf = 1'b0;
    kt = '0;
    // largest shift that still collides with the previous glyph
    for (int t = 2; t <= 32; t++) begin
      if (t <= int'(sp) && coll_acc[t-1]) begin
        kf = 1'b1;
        kt = 6'(t);
      end
    end
    if (kf) begin
      ktr = (kt < sp) ? kt + 6'd1 : kt;
    end else begin
      ktr = (sp > 6'd1) ? 6'd1 : sp;
    end
    kern = (fin.mode != gklf_pkg::KM_NONE) ? sp - ktr : 6'd0;

    // right trim of empty columns
    tf = 1'b0;
    tt = '0;
    for (int t = 2; t < 32; t++) begin
      if (t <= int'(fw) && |(union_acc & (32'hffff_ffff >> t))) begin
        tf = 1'b1;
        tt = 6'(t);
      end
    end
    if (fin.mode == gklf_pkg::KM_SOLID) begin
      ttr = fw;
    end else if (tf) begin
      ttr = (tt < fw) ? tt + 6'd1 : tt;
    end else begin
      ttr = (fw > 6'd1) ? 6'd1 : fw;
    end

    if (fin.first_glyph) begin
      kern = fw - ttr;
    end
    if (fin.is_space) begin
      fout.trim = fw >> 1;
      fout.mode = gklf_pkg::KM_NONE;
      fout.kern = fin.first_glyph ? 6'd0 : kern;
    end else begin
      fout.trim = ttr;
      fout.mode = gklf_pkg::KM_PREV;
      fout.kern = kern;
    end
  end

endmodule

/* src/gklf_checker.sv */
// ---------------------------------------------------------------------------
// gklf_checker
// port level checks of the line fitter result channel
// ---------------------------------------------------------------------------
module gklf_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic        line_full,
  input logic        wrapped,
  input logic [12:0] committed_bytes
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  a_wrap_full: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wrapped |-> line_full)
    else $error("wrap without full line");

  a_wrap_bytes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && wrapped |-> committed_bytes != 13'd0)
    else $error("wrap at empty break point");

endmodule

bind glyph_kerning_line_fitter gklf_checker u_gklf_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .out_valid       (out_if.valid),
  .out_ready       (out_if.ready),
  .line_full       (out_if.line_full),
  .wrapped         (out_if.wrapped),
  .committed_bytes (out_if.committed_bytes)
);

/* sim/testbench.sv */
// ---------------------------------------------------------------------------
// glyph kerning line fitter testbench
// streams glyph rows through the fitter with random gaps and receiver
// stalls, predicts every glyph result and compares the whole result with it
// ---------------------------------------------------------------------------
module testbench;

  localparam int NROWS   = gklf_pkg::MAX_ROWS_DEF;
  localparam int NBYTES  = gklf_pkg::MAX_TEXT_BYTES_DEF;
  localparam int WD_LIMIT = 20000;

  // one row request as the sender offers it
  typedef struct packed {
    logic [31:0] row_bits;
    logic        last_row;
    logic        start_of_text;
    logic [1:0]  char_class;
    logic [2:0]  byte_len;
  } row_req_t;

  // one glyph result
  typedef struct packed {
    logic [5:0]         kern_px;
    logic [5:0]         glyph_width;
    logic signed [13:0] line_width;
    logic               line_full;
    logic [12:0]        committed_bytes;
    logic               wrapped;
  } glyph_res_t;

  logic clk;
  logic rst_n;

  gklf_in_if  in_if();
  gklf_out_if out_if();
  gklf_cfg_if cfg_if();

  glyph_kerning_line_fitter i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if.sink),
    .out_if (out_if.source),
    .cfg_if (cfg_if.sink)
  );

  // register shadow of the fitter
  int unsigned fw_reg, fh_reg, box_reg, indent_reg;

  // layout state mirrored from the block
  logic [31:0] prev_rows [NROWS];
  logic [31:0] cur_rows  [NROWS];
  int unsigned row_cnt, prev_trim, kmode_cur, bytes_used, break_bytes;
  bit          first_glyph, line_is_full;
  int          run_width, break_w;

  row_req_t   row_queue[$];
  glyph_res_t expected_results[$];

  int  mismatch_cnt;
  bit  sender_done;
  bit  hold_off;
  int  long_hold;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic int clamp_width(int v);
    if (v > gklf_pkg::WIDTH_MAX) return gklf_pkg::WIDTH_MAX;
    if (v < gklf_pkg::WIDTH_MIN) return gklf_pkg::WIDTH_MIN;
    return v;
  endfunction

  function automatic logic [31:0] shift_right(logic [31:0] v, int unsigned s);
    return (s >= 32) ? 32'd0 : (v >> s);
  endfunction

  function automatic logic [31:0] shift_left(logic [31:0] v, int unsigned s);
    return (s >= 32) ? 32'd0 : (v << s);
  endfunction

  task automatic clear_layout();
    for (int m = 0; m < NROWS; m++) begin
      prev_rows[m] = '0;
      cur_rows[m]  = '0;
    end
    row_cnt      = 0;
    prev_trim    = fw_reg;
    kmode_cur    = gklf_pkg::KM_NONE;
    first_glyph  = 1'b1;
    run_width    = 0;
    bytes_used   = 0;
    break_bytes  = 0;
    break_w      = 0;
    line_is_full = 1'b0;
  endtask

  function automatic glyph_res_t pack_res(int unsigned k, int unsigned g, int w, bit full,
                                          int unsigned b, bit wrap);
    glyph_res_t r;
    r.kern_px         = k[5:0];
    r.glyph_width     = g[5:0];
    r.line_width      = w[13:0];
    r.line_full       = full;
    r.committed_bytes = b[12:0];
    r.wrapped         = wrap;
    return r;
  endfunction

  // full line report, cut back to the last break when there is one
  function automatic glyph_res_t full_line_res(int unsigned k, int unsigned g);
    line_is_full = 1'b1;
    if (break_bytes != 0) return pack_res(k, g, break_w, 1'b1, break_bytes, 1'b1);
    return pack_res(k, g, run_width, 1'b1, bytes_used, 1'b0);
  endfunction

  // advance the layout by one accepted row, queueing the glyph result if any
  task automatic fit_row(row_req_t r);
    logic [31:0] cur [NROWS];
    logic [31:0] mask, probe;
    int unsigned h, tr, kern, mode, sp;
    bit is_space, is_punct;
    h = (fh_reg < NROWS) ? fh_reg : NROWS;
    is_space = (r.char_class == gklf_pkg::CLS_SPACE);
    is_punct = (r.char_class == gklf_pkg::CLS_PUNCT);
    if (r.start_of_text) clear_layout();
    if (row_cnt < h) cur_rows[row_cnt] = r.row_bits;
    if (row_cnt < NROWS) row_cnt++;
    if (!r.last_row) return;
    for (int m = 0; m < NROWS; m++) cur[m] = (m < row_cnt && m < h) ? cur_rows[m] : '0;
    row_cnt = 0;
    if (line_is_full || bytes_used >= NBYTES) return;
    if (run_width + int'(indent_reg) >= int'(box_reg)) begin
      expected_results.push_back(full_line_res(0, 0));
      return;
    end
    mode = kmode_cur;
    if (is_space && mode != gklf_pkg::KM_NONE) mode = gklf_pkg::KM_SOLID;
    // kern search against the previous profile, spaces probe as solid
    tr = prev_trim;
    kern = 0;
    if (mode != gklf_pkg::KM_NONE) begin
      probe = (mode == gklf_pkg::KM_SOLID) ? 32'hffff_ffff : 32'd0;
      sp = tr;
      while (tr > 1) begin
        mask = '0;
        for (int m = 0; m < h; m++) mask |= prev_rows[m] & shift_right(cur[m] | probe, tr - 1);
        if (mask != 0) begin
          if (tr < sp) tr++;
          break;
        end
        tr--;
      end
      kern = sp - tr;
    end
    // trim empty columns on the right
    tr = fw_reg;
    while (tr > 1 && mode != gklf_pkg::KM_SOLID) begin
      mask = '0;
      for (int m = 0; m < h; m++) mask |= shift_left(cur[m], tr);
      if (mask != 0) begin
        if (tr < fw_reg) tr++;
        break;
      end
      tr--;
    end
    if (first_glyph) kern = fw_reg - tr;
    if (is_space) begin
      tr = fw_reg / 2;
      mode = gklf_pkg::KM_NONE;
      if (first_glyph) kern = 0;
    end else begin
      mode = gklf_pkg::KM_PREV;
    end
    if (is_space) begin
      break_bytes = bytes_used + r.byte_len;
      break_w = clamp_width(run_width - int'(kern));
    end
    run_width = clamp_width(run_width - int'(kern) + int'(tr) + 1);
    bytes_used += r.byte_len;
    if (bytes_used > NBYTES) bytes_used = NBYTES;
    if (is_punct) begin
      break_bytes = bytes_used;
      break_w = run_width;
    end
    if (break_bytes > NBYTES) break_bytes = NBYTES;
    for (int m = 0; m < NROWS; m++) prev_rows[m] = cur[m];
    prev_trim = tr & 6'h3f;
    kmode_cur = mode;
    first_glyph = 1'b0;
    if (run_width + int'(indent_reg) >= int'(box_reg))
      expected_results.push_back(full_line_res(kern, tr));
    else
      expected_results.push_back(pack_res(kern, tr, run_width, 1'b0, bytes_used, 1'b0));
  endtask

  // sender: offers queued rows with random gaps
  int gap_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_if.valid <= 1'b0;
      gap_cnt <= 0;
    end else begin
      if (in_if.valid && in_if.ready) fit_row(row_req_t'({in_if.row_bits, in_if.last_row,
          in_if.start_of_text, in_if.char_class, in_if.byte_len}));
      if (!in_if.valid || in_if.ready) begin
        if (gap_cnt > 0) begin
          gap_cnt <= gap_cnt - 1;
          in_if.valid <= 1'b0;
        end else if (row_queue.size() > 0) begin
          row_req_t nx;
          nx = row_queue.pop_front();
          in_if.valid         <= 1'b1;
          in_if.row_bits      <= nx.row_bits;
          in_if.last_row      <= nx.last_row;
          in_if.start_of_text <= nx.start_of_text;
          in_if.char_class    <= nx.char_class;
          in_if.byte_len      <= nx.byte_len;
          if ($urandom_range(0, 3) == 0)
            gap_cnt <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 60)
                                                    : $urandom_range(1, 3);
        end else begin
          in_if.valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random ready, plus a long hold-off on request
  int stall_cnt;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_if.ready <= 1'b0;
      stall_cnt <= 0;
    end else if (hold_off) begin
      out_if.ready <= 1'b0;
    end else if (stall_cnt > 0) begin
      stall_cnt <= stall_cnt - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if ($urandom_range(0, 4) == 0)
        stall_cnt <= ($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
                                                  : $urandom_range(1, 3);
    end
  end

  // long receiver stall counted in its own process
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_off <= 1'b0;
    end else if (long_hold > 0) begin
      hold_off <= 1'b1;
      long_hold <= long_hold - 1;
    end else begin
      hold_off <= 1'b0;
    end
  end

  // monitor: compare each result with the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready) begin
      glyph_res_t got, exp_r;
      got = pack_res(out_if.kern_px, out_if.glyph_width, out_if.line_width,
                     out_if.line_full, out_if.committed_bytes, out_if.wrapped);
      if (expected_results.size() == 0) begin
        mismatch_cnt++;
        if (mismatch_cnt <= 10) $display("unexpected result %p", got);
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          mismatch_cnt++;
          if (mismatch_cnt <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
        end
      end
    end
  end

  // watchdog on cycles without any accepted request
  int idle_cycles;
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WD_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  task automatic write_reg(gklf_pkg::cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data  <= val[11:0];
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      gklf_pkg::CFG_FONT_WIDTH:  fw_reg = val & 6'h3f;
      gklf_pkg::CFG_FONT_HEIGHT: fh_reg = val & 6'h3f;
      gklf_pkg::CFG_BOX_WIDTH:   box_reg = val & 12'hfff;
      default:                   indent_reg = val & 12'hfff;
    endcase
  endtask

  // wait until all rows are taken, all results seen and the block is quiet
  task automatic drain();
    while (row_queue.size() > 0 || in_if.valid || expected_results.size() > 0)
      @(posedge clk);
    repeat (2 * NROWS + 20) @(posedge clk);
  endtask

  function automatic logic [31:0] glyph_row();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'hffff_ffff;
      2: return $urandom() & 32'hff00_0000;
      default: return $urandom();
    endcase
  endfunction

  // queue one glyph of the given number of rows
  task automatic add_glyph(int rows, bit sot, logic [1:0] cls, logic [2:0] blen);
    row_req_t r;
    for (int i = 0; i < rows; i++) begin
      r.row_bits      = glyph_row();
      r.last_row      = (i == rows - 1);
      r.start_of_text = sot && (i == 0);
      r.char_class    = cls;
      r.byte_len      = blen;
      row_queue.push_back(r);
    end
  endtask

  task automatic random_text(int n_rows, int hmax);
    int sent;
    sent = 0;
    while (sent < n_rows) begin
      int rows;
      bit sot;
      rows = ($urandom_range(0, 9) == 0) ? $urandom_range(1, hmax + 3) : hmax;
      if (rows < 1) rows = 1;
      sot = ($urandom_range(0, 30) == 0);
      add_glyph(rows, sot, ($urandom_range(0, 3) == 0) ? gklf_pkg::CLS_SPACE
                                                      : 2'($urandom_range(0, 3)),
                3'($urandom_range(0, 7)));
      sent += rows;
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.row_bits = '0;
    in_if.last_row = 1'b0;
    in_if.start_of_text = 1'b0;
    in_if.char_class = '0;
    in_if.byte_len = '0;
    out_if.ready = 1'b0;
    cfg_if.valid = 1'b0;
    cfg_if.index = gklf_pkg::CFG_FONT_WIDTH;
    cfg_if.data = '0;
    hold_off = 1'b0;
    long_hold = 0;
    mismatch_cnt = 0;
    fw_reg = 8; fh_reg = 16; box_reg = 320; indent_reg = 0;
    clear_layout();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: default registers, every class, byte length extremes
    add_glyph(16, 1'b1, gklf_pkg::CLS_ORD, 3'd1);
    add_glyph(16, 1'b0, gklf_pkg::CLS_SPACE, 3'd4);
    add_glyph(16, 1'b0, gklf_pkg::CLS_PUNCT, 3'd0);
    add_glyph(16, 1'b0, 2'd3, 3'd7);  // class three counts as ordinary
    add_glyph(3, 1'b0, gklf_pkg::CLS_ORD, 3'd2);   // short glyph, missing rows count as zero
    add_glyph(20, 1'b0, gklf_pkg::CLS_SPACE, 3'd1);  // rows past font height ignored
    drain();

    // narrow box: full line, wrap and ignored glyphs until new text
    write_reg(gklf_pkg::CFG_FONT_WIDTH, 32);
    write_reg(gklf_pkg::CFG_FONT_HEIGHT, 4);
    write_reg(gklf_pkg::CFG_BOX_WIDTH, 60);
    add_glyph(4, 1'b1, gklf_pkg::CLS_ORD, 3'd1);
    add_glyph(4, 1'b0, gklf_pkg::CLS_SPACE, 3'd1);
    add_glyph(4, 1'b0, gklf_pkg::CLS_ORD, 3'd2);
    add_glyph(4, 1'b0, gklf_pkg::CLS_ORD, 3'd2);
    add_glyph(4, 1'b0, gklf_pkg::CLS_ORD, 3'd2);
    drain();

    // indent already past the box: full before any glyph
    write_reg(gklf_pkg::CFG_LINE_INDENT, 4095);
    write_reg(gklf_pkg::CFG_FONT_HEIGHT, 1);
    add_glyph(1, 1'b1, gklf_pkg::CLS_ORD, 3'd3);
    add_glyph(1, 1'b1, gklf_pkg::CLS_PUNCT, 3'd3);
    drain();

    // pressure: receiver holds off while glyphs keep arriving
    write_reg(gklf_pkg::CFG_LINE_INDENT, 0);
    write_reg(gklf_pkg::CFG_BOX_WIDTH, 4095);
    write_reg(gklf_pkg::CFG_FONT_WIDTH, 1);
    long_hold = 600;
    random_text(60, 1);
    drain();

    // random phases over several settings, extremes included
    for (int ph = 0; ph < 8; ph++) begin
      int unsigned hh;
      hh = (ph == 0) ? 32 : (ph == 1) ? 1 : $urandom_range(1, 8);
      write_reg(gklf_pkg::CFG_FONT_WIDTH,
                (ph == 0) ? 32 : (ph == 1) ? 1 : $urandom_range(1, 32));
      write_reg(gklf_pkg::CFG_FONT_HEIGHT, (ph == 2) ? 40 : hh);
      write_reg(gklf_pkg::CFG_BOX_WIDTH,
                (ph == 3) ? 0 : (ph == 4) ? 4095 : $urandom_range(20, 400));
      write_reg(gklf_pkg::CFG_LINE_INDENT, (ph == 5) ? 4095 : $urandom_range(0, 30));
      add_glyph(1, 1'b1, gklf_pkg::CLS_ORD, 3'd1);
      random_text(150, (ph == 2) ? 8 : hh);
      drain();
    end

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
